### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BTI_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define BTI_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define BTI_ASSERT(lbl, clk, rstn, prop)
`define BTI_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

### sv/bti_pkg.sv
// ----------------------------------------------------------------------------
// bti_pkg
// Types and constants of the bilinear table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;

	localparam int MAX_ROWS_DEF    = 64;
	localparam int MAX_COLUMNS_DEF = 64;
	localparam int QUEUE_DEPTH     = 4;
	localparam int DIV_NW          = 64;
	localparam int DIV_DW          = 31;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [2:0] REG_ORIGIN_D = 3'd0;
	localparam logic [2:0] REG_STEP_D   = 3'd1;
	localparam logic [2:0] REG_ROWS     = 3'd2;
	localparam logic [2:0] REG_ORIGIN_T = 3'd3;
	localparam logic [2:0] REG_STEP_T   = 3'd4;
	localparam logic [2:0] REG_COLS     = 3'd5;

	typedef struct packed {
		logic signed [31:0] origin_distance;
		logic        [30:0] step_distance;
		logic        [6:0]  rows_used;
		logic signed [31:0] origin_temperature;
		logic        [30:0] step_temperature;
		logic        [6:0]  columns_used;
	} cfg_t;

	typedef struct packed {
		logic               cmd;
		logic        [5:0]  row_index;
		logic        [5:0]  column_index;
		logic signed [31:0] entry_value;
		logic signed [32:0] off_d;
		logic signed [32:0] off_t;
	} item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DVD_GO,
		S_DVD_WAIT,
		S_DVT_GO,
		S_DVT_WAIT,
		S_READ,
		S_MUL,
		S_BL_GO,
		S_BL_WAIT,
		S_OUT
	} state_t;

endpackage

### sv/bti_ram.sv
// ----------------------------------------------------------------------------
// bti_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/bti_divider.sv
// ----------------------------------------------------------------------------
// bti_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bti_divider #(
	parameter int NW = bti_pkg::DIV_NW,
	parameter int DW = bti_pkg::DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic [DW-1:0] remainder
);

	localparam int CNTW = $clog2(NW);

	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     shifted;
	logic [DW+1:0]   diff;
	logic            ge;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = !diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### sv/bti_front.sv
// ----------------------------------------------------------------------------
// bti_front
// Accepts words, forms axis offsets and queues them for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bti_front #(
	parameter int DEPTH = bti_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bti_pkg::cfg_t       cfg,
	input  logic                push,
	output logic                full,
	input  logic                cmd,
	input  logic [5:0]          row_index,
	input  logic [5:0]          column_index,
	input  logic signed [31:0]  entry_value,
	input  logic signed [31:0]  query_distance,
	input  logic signed [31:0]  query_temperature,
	output bti_pkg::item_t      q_item,
	output logic                q_valid,
	input  logic                q_pop
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	bti_pkg::item_t mem_q [DEPTH];
	bti_pkg::item_t item_in;
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           wr_en;
	logic           rd_en;

	always_comb begin
		item_in.cmd          = cmd;
		item_in.row_index    = row_index;
		item_in.column_index = column_index;
		item_in.entry_value  = entry_value;
		item_in.off_d        = 33'(query_distance) - 33'(cfg.origin_distance);
		item_in.off_t        = 33'(query_temperature) - 33'(cfg.origin_temperature);
	end

	assign full    = (cnt_q == CW'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_ptr_q];
	assign wr_en   = push && !full;
	assign rd_en   = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`BTI_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CW'(DEPTH))
	`BTI_ASSERT_NEXT(a_push_counts, clk, arst_n, wr_en && !rd_en, cnt_q != '0)

endmodule

### sv/bti_back.sv
// ----------------------------------------------------------------------------
// bti_back
// Executes queued words: grid writes, cell location, corner reads, blends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bti_back #(
	parameter int MAX_ROWS    = bti_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = bti_pkg::MAX_COLUMNS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bti_pkg::cfg_t      cfg,
	input  bti_pkg::item_t     q_item,
	input  logic               q_valid,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic signed [31:0] interpolated_value,
	output logic               in_range
);

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLUMNS);
	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = bti_pkg::DIV_NW;
	localparam int DW    = bti_pkg::DIV_DW;

	bti_pkg::state_t    state_q, state_d;

	logic signed [32:0] off_d_q, off_t_q;
	logic [RW-1:0]      d0_q;
	logic [CW-1:0]      t0_q;
	logic signed [31:0] frac_d_q, frac_t_q;
	logic               ok_d_q;
	logic [2:0]         rd_cnt_q;
	logic signed [31:0] corner_q [4];
	logic [1:0]         bl_q;
	logic signed [63:0] prod_s1;
	logic signed [31:0] mix_q [2];
	logic signed [31:0] res_value_q;
	logic               res_ok_q;
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic               out_range_q;

	logic               div_start, div_busy, div_done;
	logic [NW-1:0]      div_n, div_quo;
	logic [DW-1:0]      div_dv, div_rem;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [31:0]        ram_rdata;
	logic               out_load;
	logic               step_zero;

	logic [32:0]        abs_off_d, abs_off_t;
	logic [63:0]        abs_prod;
	logic               ax_neg;
	logic [31:0]        ax_used;
	logic               ax_ok;
	logic signed [31:0] ax_frac;
	logic [31:0]        used_d, used_t;

	logic [RW-1:0]      rd_row;
	logic [CW-1:0]      rd_col;

	logic signed [31:0] a_sel, b_sel, f_sel;
	logic signed [32:0] diff;
	logic signed [64:0] prod_full;
	logic signed [34:0] q_signed, blend_sum;
	logic signed [31:0] blend_res;

	bti_divider #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_n),
		.divisor   (div_dv),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	bti_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (q_item.entry_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// operand and datapath logic
	assign step_zero = (cfg.step_distance == '0) || (cfg.step_temperature == '0);
	assign abs_off_d = off_d_q[32] ? 33'(-off_d_q) : off_d_q;
	assign abs_off_t = off_t_q[32] ? 33'(-off_t_q) : off_t_q;
	assign abs_prod  = prod_s1[63] ? 64'(-prod_s1) : prod_s1;
	assign used_d    = (32'(cfg.rows_used) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
		: 32'(cfg.rows_used);
	assign used_t    = (32'(cfg.columns_used) > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS)
		: 32'(cfg.columns_used);

	assign ram_waddr = AW'(32'(q_item.row_index) * 32'(MAX_COLUMNS)
		+ 32'(q_item.column_index));
	assign rd_row    = d0_q + RW'(rd_cnt_q[0]);
	assign rd_col    = t0_q + CW'(rd_cnt_q[1]);
	assign ram_raddr = AW'(32'(rd_row) * 32'(MAX_COLUMNS) + 32'(rd_col));

	always_comb begin
		ax_neg  = (state_q == bti_pkg::S_DVD_WAIT) ? off_d_q[32] : off_t_q[32];
		ax_used = (state_q == bti_pkg::S_DVD_WAIT) ? used_d : used_t;
		ax_ok   = (!ax_neg || (div_quo == '0))
			&& (({1'b0, div_quo} + 65'd1) < 65'(ax_used));
		ax_frac = ax_neg ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});
	end

	always_comb begin
		case (bl_q)
			2'd0: begin
				a_sel = corner_q[0];
				b_sel = corner_q[1];
				f_sel = frac_d_q;
			end
			2'd1: begin
				a_sel = corner_q[2];
				b_sel = corner_q[3];
				f_sel = frac_d_q;
			end
			default: begin
				a_sel = mix_q[0];
				b_sel = mix_q[1];
				f_sel = frac_t_q;
			end
		endcase
		diff      = 33'(b_sel) - 33'(a_sel);
		prod_full = diff * f_sel;
		q_signed  = prod_s1[63] ? -$signed({1'b0, div_quo[33:0]})
			: $signed({1'b0, div_quo[33:0]});
		blend_sum = 35'(a_sel) + q_signed;
		if (blend_sum > 35'sd2147483647) begin
			blend_res = 32'sh7fffffff;
		end else if (blend_sum < -35'sd2147483648) begin
			blend_res = 32'sh80000000;
		end else begin
			blend_res = blend_sum[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bti_pkg::S_IDLE: begin
				if (q_valid && q_item.cmd == bti_pkg::CMD_QUERY) begin
					state_d = step_zero ? bti_pkg::S_OUT : bti_pkg::S_DVD_GO;
				end
			end
			bti_pkg::S_DVD_GO:   state_d = bti_pkg::S_DVD_WAIT;
			bti_pkg::S_DVD_WAIT: begin
				if (div_done) begin
					state_d = bti_pkg::S_DVT_GO;
				end
			end
			bti_pkg::S_DVT_GO:   state_d = bti_pkg::S_DVT_WAIT;
			bti_pkg::S_DVT_WAIT: begin
				if (div_done) begin
					state_d = (ok_d_q && ax_ok) ? bti_pkg::S_READ : bti_pkg::S_OUT;
				end
			end
			bti_pkg::S_READ: begin
				if (rd_cnt_q == 3'd4) begin
					state_d = bti_pkg::S_MUL;
				end
			end
			bti_pkg::S_MUL:      state_d = bti_pkg::S_BL_GO;
			bti_pkg::S_BL_GO:    state_d = bti_pkg::S_BL_WAIT;
			bti_pkg::S_BL_WAIT: begin
				if (div_done) begin
					state_d = (bl_q == 2'd2) ? bti_pkg::S_OUT : bti_pkg::S_MUL;
				end
			end
			bti_pkg::S_OUT: begin
				if (!out_valid_q || pop) begin
					state_d = bti_pkg::S_IDLE;
				end
			end
			default: state_d = bti_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		div_n     = '0;
		div_dv    = cfg.step_distance;
		out_load  = 1'b0;
		case (state_q)
			bti_pkg::S_IDLE: begin
				q_pop  = q_valid;
				ram_we = q_valid && (q_item.cmd == bti_pkg::CMD_WRITE)
					&& (32'(q_item.row_index) < 32'(MAX_ROWS))
					&& (32'(q_item.column_index) < 32'(MAX_COLUMNS));
			end
			bti_pkg::S_DVD_GO: begin
				div_start = 1'b1;
				div_n     = NW'(abs_off_d);
			end
			bti_pkg::S_DVT_GO: begin
				div_start = 1'b1;
				div_n     = NW'(abs_off_t);
				div_dv    = cfg.step_temperature;
			end
			bti_pkg::S_BL_GO: begin
				div_start = 1'b1;
				div_n     = abs_prod;
				div_dv    = (bl_q == 2'd2) ? cfg.step_temperature : cfg.step_distance;
			end
			bti_pkg::S_OUT: begin
				out_load = !out_valid_q || pop;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bti_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			rd_cnt_q    <= '0;
			bl_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == bti_pkg::S_READ) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end else begin
				rd_cnt_q <= '0;
			end
			if (state_q == bti_pkg::S_READ) begin
				bl_q <= '0;
			end else if (state_q == bti_pkg::S_BL_WAIT && div_done) begin
				bl_q <= bl_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bti_pkg::S_IDLE && q_pop) begin
			off_d_q     <= q_item.off_d;
			off_t_q     <= q_item.off_t;
			res_value_q <= '0;
			res_ok_q    <= 1'b0;
		end
		if (state_q == bti_pkg::S_DVD_WAIT && div_done) begin
			d0_q     <= div_quo[RW-1:0];
			frac_d_q <= ax_frac;
			ok_d_q   <= ax_ok;
		end
		if (state_q == bti_pkg::S_DVT_WAIT && div_done) begin
			t0_q     <= div_quo[CW-1:0];
			frac_t_q <= ax_frac;
		end
		if (state_q == bti_pkg::S_READ && rd_cnt_q != 3'd0) begin
			corner_q[rd_cnt_q[1:0] - 2'd1] <= ram_rdata;
		end
		if (state_q == bti_pkg::S_MUL) begin
			prod_s1 <= prod_full[63:0];
		end
		if (state_q == bti_pkg::S_BL_WAIT && div_done) begin
			case (bl_q)
				2'd0: mix_q[0] <= blend_res;
				2'd1: mix_q[1] <= blend_res;
				default: begin
					res_value_q <= blend_res;
					res_ok_q    <= 1'b1;
				end
			endcase
		end
		if (out_load) begin
			out_value_q <= res_value_q;
			out_range_q <= res_ok_q;
		end
	end

	assign empty              = !out_valid_q;
	assign interpolated_value = out_value_q;
	assign in_range           = out_range_q;

	`BTI_ASSERT(a_div_start_free, clk, arst_n, div_start |-> !div_busy)
	`BTI_ASSERT(a_zero_out_of_range, clk, arst_n,
		(out_valid_q && !out_range_q) |-> (out_value_q == '0))
	`BTI_ASSERT(a_write_no_query, clk, arst_n, ram_we |-> !div_busy)

endmodule

### sv/bilinear_table_interpolator.sv
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// Bilinear lookup over a distance x temperature grid of Q16.16 samples.
// ----------------------------------------------------------------------------
// Input queue side: a word is taken when push is high and full is low. cmd
// write stores entry_value at (row_index, column_index) and returns nothing;
// cmd query returns one word of interpolated_value and in_range.
// Result queue side: the oldest result shows while empty is low and leaves
// on pop. Results come back in query order.
// A four-word input queue sits in front of the sequencer, so words are still
// taken while a result waits on a stalled receiver; full rises only when
// that queue fills behind a busy or stalled back end.
// A query makes five passes of the shared bit-serial divider (two for the
// cell index and three for the blends) and four corner reads from the
// single grid RAM port. Queries with a zero step skip the divider; other
// out-of-range queries skip the corner reads and blends.
// Reset clears queue, result and register state; grid entries stay
// undefined until written. Configuration writes via cfg_we are registered;
// origins apply to words pushed afterwards, steps and sizes to queries as
// the back end runs them.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator #(
	parameter int MAX_ROWS    = bti_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLUMNS = bti_pkg::MAX_COLUMNS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic               cmd,
	input  logic [5:0]         row_index,
	input  logic [5:0]         column_index,
	input  logic signed [31:0] entry_value,
	input  logic signed [31:0] query_distance,
	input  logic signed [31:0] query_temperature,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] interpolated_value,
	output logic               in_range
);

	bti_pkg::cfg_t  cfg_q;
	bti_pkg::item_t q_item;
	logic           q_valid;
	logic           q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_distance    <= '0;
			cfg_q.step_distance      <= 31'd65536;
			cfg_q.rows_used          <= 7'd64;
			cfg_q.origin_temperature <= '0;
			cfg_q.step_temperature   <= 31'd65536;
			cfg_q.columns_used       <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				bti_pkg::REG_ORIGIN_D: cfg_q.origin_distance    <= cfg_wdata;
				bti_pkg::REG_STEP_D:   cfg_q.step_distance      <= cfg_wdata[30:0];
				bti_pkg::REG_ROWS:     cfg_q.rows_used          <= cfg_wdata[6:0];
				bti_pkg::REG_ORIGIN_T: cfg_q.origin_temperature <= cfg_wdata;
				bti_pkg::REG_STEP_T:   cfg_q.step_temperature   <= cfg_wdata[30:0];
				bti_pkg::REG_COLS:     cfg_q.columns_used       <= cfg_wdata[6:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	bti_front #(
		.DEPTH (bti_pkg::QUEUE_DEPTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.push              (push),
		.full              (full),
		.cmd               (cmd),
		.row_index         (row_index),
		.column_index      (column_index),
		.entry_value       (entry_value),
		.query_distance    (query_distance),
		.query_temperature (query_temperature),
		.q_item            (q_item),
		.q_valid           (q_valid),
		.q_pop             (q_pop)
	);

	bti_back #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.q_item             (q_item),
		.q_valid            (q_valid),
		.q_pop              (q_pop),
		.pop                (pop),
		.empty              (empty),
		.interpolated_value (interpolated_value),
		.in_range           (in_range)
	);

endmodule
